/* design/assert_macros.svh */
// Shared assertion macros for the vertex transform block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The antecedent and the consequent hold in the same cycle.
`define ERP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define ERP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/erp_pkg.sv */
// ----------------------------------------------------------------------------
// erp_pkg
// Shared types, constants and the saturation helper of the vertex transform block.
// ----------------------------------------------------------------------------
package erp_pkg;

    typedef logic signed [44:0] t_mcoef;
    typedef t_mcoef t_mat [0:2][0:2];

    typedef enum logic [2:0] {
        REG_ANGLE_X     = 3'd0,
        REG_ANGLE_Y     = 3'd1,
        REG_ANGLE_Z     = 3'd2,
        REG_FOCAL       = 3'd3,
        REG_CAMERA      = 3'd4,
        REG_DEPTH_RECIP = 3'd5
    } t_reg_idx;

    localparam logic [23:0] FOCAL_RESET  = 24'd113512;
    localparam logic [23:0] CAMERA_RESET = 24'd196608;
    localparam logic [23:0] RECIP_RESET  = 24'd65536;

    localparam logic [14:0] QUARTER_TURN = 15'd16384;
    localparam logic [15:0] COS_OFFSET   = 16'd16384;
    localparam logic [10:0] SIN_C        = 11'd1160;
    localparam logic [13:0] SIN_B        = 14'd10512;
    localparam logic [14:0] SIN_A        = 15'd25736;

    // Settling count, loaded at reset and on every configuration write; input ready waits for it to reach zero.
    localparam logic [3:0] SETTLE_CYCLES = 4'd8;

    function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
        logic signed [51:0] hi;
        logic signed [51:0] lo;
        hi = 52'sd2147483647;
        lo = -52'sd2147483648;
        if (v > hi) begin
            sat32 = 32'sh7FFFFFFF;
        end else if (v < lo) begin
            sat32 = 32'sh80000000;
        end else begin
            sat32 = v[31:0];
        end
    endfunction

endpackage

/* design/erp_trig.sv */
// ----------------------------------------------------------------------------
// erp_trig
// Four-stage polynomial sine of a 16-bit angle, Q1.14 signed result.
// ----------------------------------------------------------------------------
module erp_trig (
    input  logic               i_clk,
    input  logic [15:0]        i_angle,
    output logic signed [15:0] o_sine
);

    logic [14:0] n_t;
    logic [29:0] n_sq;
    logic [14:0] r_t1, r_t2, r_t3;
    logic [14:0] r_sq1, r_sq2;
    logic        r_neg1, r_neg2, r_neg3;
    logic [25:0] n_inner_full;
    logic [10:0] r_inner;
    logic [13:0] n_mid;
    logic [28:0] n_mid2_full;
    logic [14:0] r_mid2;
    logic [14:0] n_outer;
    logic [29:0] n_s_full;
    logic signed [15:0] n_s;
    logic signed [15:0] r_sine;

    always_comb begin
        n_t = i_angle[14] ? (erp_pkg::QUARTER_TURN - {1'b0, i_angle[13:0]})
                          : {1'b0, i_angle[13:0]};
        n_sq = n_t * n_t;
        n_inner_full = erp_pkg::SIN_C * r_sq1;
        n_mid = erp_pkg::SIN_B - {3'd0, r_inner};
        n_mid2_full = r_sq2 * n_mid;
        n_outer = erp_pkg::SIN_A - r_mid2;
        n_s_full = r_t3 * n_outer;
        n_s = $signed(n_s_full[29:14]);
    end

    always_ff @(posedge i_clk) begin
        r_t1    <= n_t;
        r_sq1   <= n_sq[28:14];
        r_neg1  <= i_angle[15];
        r_t2    <= r_t1;
        r_sq2   <= r_sq1;
        r_neg2  <= r_neg1;
        r_inner <= n_inner_full[24:14];
        r_t3    <= r_t2;
        r_neg3  <= r_neg2;
        r_mid2  <= n_mid2_full[28:14];
        r_sine  <= r_neg3 ? -n_s : n_s;
    end

    assign o_sine = r_sine;

endmodule

/* design/erp_matrix.sv */
// ----------------------------------------------------------------------------
// erp_matrix
// Builds the combined X-Y-Z rotation matrix at Q42 from the three angles.
// ----------------------------------------------------------------------------
module erp_matrix (
    input  logic          i_clk,
    input  logic [15:0]   i_angle_x,
    input  logic [15:0]   i_angle_y,
    input  logic [15:0]   i_angle_z,
    output erp_pkg::t_mat o_mat
);

    logic signed [15:0] sa, ca, sb, cb, sc, cc;
    logic signed [31:0] r_cbcc, r_cbsc, r_sasb, r_cacs, r_cacc;
    logic signed [31:0] r_sacb, r_sasc, r_casb, r_sacc, r_cacb;
    logic signed [15:0] r_sb, r_sc, r_cc;
    erp_pkg::t_mat r_mat;

    erp_trig u_sa (.i_clk(i_clk), .i_angle(i_angle_x), .o_sine(sa));
    erp_trig u_ca (.i_clk(i_clk), .i_angle(i_angle_x + erp_pkg::COS_OFFSET), .o_sine(ca));
    erp_trig u_sb (.i_clk(i_clk), .i_angle(i_angle_y), .o_sine(sb));
    erp_trig u_cb (.i_clk(i_clk), .i_angle(i_angle_y + erp_pkg::COS_OFFSET), .o_sine(cb));
    erp_trig u_sc (.i_clk(i_clk), .i_angle(i_angle_z), .o_sine(sc));
    erp_trig u_cc (.i_clk(i_clk), .i_angle(i_angle_z + erp_pkg::COS_OFFSET), .o_sine(cc));

    always_ff @(posedge i_clk) begin
        r_cbcc <= cb * cc;
        r_cbsc <= cb * sc;
        r_sasb <= sa * sb;
        r_cacs <= ca * sc;
        r_cacc <= ca * cc;
        r_sacb <= sa * cb;
        r_sasc <= sa * sc;
        r_casb <= ca * sb;
        r_sacc <= sa * cc;
        r_cacb <= ca * cb;
        r_sb   <= sb;
        r_sc   <= sc;
        r_cc   <= cc;

        r_mat[0][0] <= 45'(r_cbcc) <<< 14;
        r_mat[0][1] <= -(45'(r_cbsc) <<< 14);
        r_mat[0][2] <= 45'(r_sb) <<< 28;
        r_mat[1][0] <= 45'(r_sasb * r_cc) + (45'(r_cacs) <<< 14);
        r_mat[1][1] <= (45'(r_cacc) <<< 14) - 45'(r_sasb * r_sc);
        r_mat[1][2] <= -(45'(r_sacb) <<< 14);
        r_mat[2][0] <= (45'(r_sasc) <<< 14) - 45'(r_casb * r_cc);
        r_mat[2][1] <= 45'(r_casb * r_sc) + (45'(r_sacc) <<< 14);
        r_mat[2][2] <= 45'(r_cacb) <<< 14;
    end

    assign o_mat = r_mat;

endmodule

/* design/erp_rotate.sv */
// ----------------------------------------------------------------------------
// erp_rotate
// Input register, split matrix products, row sums and rounding to signed Q6.16.
// ----------------------------------------------------------------------------
module erp_rotate (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic signed [15:0] i_vx,
    input  logic signed [15:0] i_vy,
    input  logic signed [15:0] i_vz,
    input  erp_pkg::t_mat      i_mat,
    output logic               o_valid,
    output logic signed [22:0] o_rx,
    output logic signed [22:0] o_ry,
    output logic signed [22:0] o_rz
);

    logic signed [15:0] r_v [0:2];
    logic signed [38:0] r_pl [0:2][0:2];
    logic signed [38:0] r_ph [0:2][0:2];
    logic signed [60:0] r_sum [0:2];
    logic signed [22:0] r_r [0:2];
    logic signed [60:0] n_sum [0:2];
    logic signed [60:0] n_rnd [0:2];
    logic [3:0] r_valid;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_sum[i] = '0;
            for (int j = 0; j < 3; j++) begin
                n_sum[i] = n_sum[i] + (61'(r_ph[i][j]) <<< 22) + 61'(r_pl[i][j]);
            end
            n_rnd[i] = r_sum[i] + (61'sd1 <<< 37);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[2:0], i_valid};
        end
        if (i_en) begin
            r_v[0] <= i_vx;
            r_v[1] <= i_vy;
            r_v[2] <= i_vz;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_pl[i][j] <= r_v[j] * $signed({1'b0, i_mat[i][j][21:0]});
                    r_ph[i][j] <= r_v[j] * $signed(i_mat[i][j][44:22]);
                end
                r_sum[i] <= n_sum[i];
                r_r[i]   <= n_rnd[i][60:38];
            end
        end
    end

    assign o_valid = r_valid[3];
    assign o_rx = r_r[0];
    assign o_ry = r_r[1];
    assign o_rz = r_r[2];

endmodule

/* design/erp_project.sv */
// ----------------------------------------------------------------------------
// erp_project
// Perspective projection, rounding and saturation into the output register.
// ----------------------------------------------------------------------------
module erp_project (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic signed [22:0] i_rx,
    input  logic signed [22:0] i_ry,
    input  logic signed [22:0] i_rz,
    input  logic [23:0]        i_focal,
    input  logic [23:0]        i_camera,
    input  logic [23:0]        i_recip,
    output logic               o_valid,
    output logic signed [31:0] o_clip_x,
    output logic signed [31:0] o_clip_y,
    output logic signed [31:0] o_clip_z,
    output logic signed [31:0] o_clip_w
);

    logic signed [22:0] r_rx, r_ry;
    logic signed [25:0] r_w1, r_w2;
    logic signed [26:0] r_dz;
    logic signed [47:0] r_px, r_py;
    logic signed [51:0] r_pz;
    logic signed [31:0] r_cx, r_cy, r_cz, r_cw;
    logic signed [25:0] n_w;
    logic [2:0] r_valid;

    assign n_w = 26'(i_rz) + $signed({2'b00, i_camera});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[1:0], i_valid};
        end
        if (i_en) begin
            r_rx <= i_rx;
            r_ry <= i_ry;
            r_w1 <= n_w;
            r_dz <= 27'(n_w) - $signed({3'b000, i_focal});
            r_px <= r_rx * $signed({1'b0, i_focal});
            r_py <= r_ry * $signed({1'b0, i_focal});
            r_pz <= r_dz * $signed({1'b0, i_recip});
            r_w2 <= r_w1;
            r_cx <= erp_pkg::sat32((52'(r_px) + 52'sd32768) >>> 16);
            r_cy <= erp_pkg::sat32((52'(r_py) + 52'sd32768) >>> 16);
            r_cz <= erp_pkg::sat32((r_pz + 52'sd32768) >>> 16);
            r_cw <= 32'(r_w2);
        end
    end

    assign o_valid  = r_valid[2];
    assign o_clip_x = r_cx;
    assign o_clip_y = r_cy;
    assign o_clip_z = r_cz;
    assign o_clip_w = r_cw;

endmodule

/* design/euler_rotate_project_vertex.sv */
// ----------------------------------------------------------------------------
// euler_rotate_project_vertex
// Rotates a vertex by three Euler angles and projects it to clip space.
// ----------------------------------------------------------------------------
// A vertex word (vx, vy, vz) enters on the input valid/ready channel and one
// clip-space word (clip_x, clip_y, clip_z, clip_w) leaves on the output
// valid/ready channel. Registers are written through the plain write port.
// The datapath has seven register stages: input register, split products,
// row sums, rounding, projection operands, projection products and output.
// One word can be accepted in every cycle while not stalled or settling.
// The rotation matrix is rebuilt from the angles by a free-running sine and
// matrix pipeline; after reset and after every register write, input ready
// stays low while that pipeline settles.
// Reset clears all valid bits and loads the register defaults.
// When the receiver holds ready low with a word waiting, the whole datapath
// freezes; no word is lost or repeated, and input ready drops until the
// output word is taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module euler_rotate_project_vertex (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [15:0] i_vx,
    input  logic signed [15:0] i_vy,
    input  logic signed [15:0] i_vz,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_clip_x,
    output logic signed [31:0] o_clip_y,
    output logic signed [31:0] o_clip_z,
    output logic signed [31:0] o_clip_w,
    input  logic               i_cfg_wr_en,
    input  logic [2:0]         i_cfg_index,
    input  logic [23:0]        i_cfg_data
);

    logic [15:0] r_angle_x, r_angle_y, r_angle_z;
    logic [23:0] r_focal, r_camera, r_recip;
    logic [3:0]  r_settle;
    logic        en;
    logic        accept;
    erp_pkg::t_mat mat;
    logic        rot_valid;
    logic signed [22:0] rx, ry, rz;

    assign en      = !o_valid || i_ready;
    assign o_ready = en && (r_settle == 4'd0);
    assign accept  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle_x <= '0;
            r_angle_y <= '0;
            r_angle_z <= '0;
            r_focal   <= erp_pkg::FOCAL_RESET;
            r_camera  <= erp_pkg::CAMERA_RESET;
            r_recip   <= erp_pkg::RECIP_RESET;
            r_settle  <= erp_pkg::SETTLE_CYCLES;
        end else begin
            if (i_cfg_wr_en) begin
                r_settle <= erp_pkg::SETTLE_CYCLES;
                case (i_cfg_index)
                    erp_pkg::REG_ANGLE_X:     r_angle_x <= i_cfg_data[15:0];
                    erp_pkg::REG_ANGLE_Y:     r_angle_y <= i_cfg_data[15:0];
                    erp_pkg::REG_ANGLE_Z:     r_angle_z <= i_cfg_data[15:0];
                    erp_pkg::REG_FOCAL:       r_focal   <= i_cfg_data;
                    erp_pkg::REG_CAMERA:      r_camera  <= i_cfg_data;
                    erp_pkg::REG_DEPTH_RECIP: r_recip   <= i_cfg_data;
                    default: ;
                endcase
            end else if (r_settle != 4'd0) begin
                r_settle <= r_settle - 4'd1;
            end
        end
    end

    erp_matrix u_matrix (
        .i_clk(i_clk), .i_angle_x(r_angle_x), .i_angle_y(r_angle_y),
        .i_angle_z(r_angle_z), .o_mat(mat)
    );

    erp_rotate u_rotate (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(accept),
        .i_vx(i_vx), .i_vy(i_vy), .i_vz(i_vz), .i_mat(mat),
        .o_valid(rot_valid), .o_rx(rx), .o_ry(ry), .o_rz(rz)
    );

    erp_project u_project (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(rot_valid),
        .i_rx(rx), .i_ry(ry), .i_rz(rz),
        .i_focal(r_focal), .i_camera(r_camera), .i_recip(r_recip),
        .o_valid(o_valid), .o_clip_x(o_clip_x), .o_clip_y(o_clip_y),
        .o_clip_z(o_clip_z), .o_clip_w(o_clip_w)
    );

    `ERP_ASSERT_NEXT(a_write_blocks_input, i_cfg_wr_en, !o_ready, "input ready after a write")
    `ERP_ASSERT_SAME(a_no_accept_settling, accept, r_settle == 4'd0, "word taken while settling")
    `ERP_ASSERT_NEXT(a_stall_holds_output, o_valid && !i_ready,
        o_valid && $stable(o_clip_z) && $stable(o_clip_w), "stalled output word changed")

endmodule
